[hdl/sorted_priority_queue_macros.svh]
// Assertion macros used by the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("queue check failed");

// The consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("queue check failed");

`endif

[hdl/spq_pkg.sv]
`timescale 1ns / 1ps
package spq_pkg;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LIST   = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_REMOVED  = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BAD_PRIO = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_LISTED   = 3'd5;
	localparam logic [2:0] ST_CLEARED  = 3'd6;

	localparam logic [3:0] PRIO_MIN = 4'd1;
	localparam logic [3:0] PRIO_MAX = 4'd10;

	localparam logic [15:0] ID_FIRST = 16'd1;
	localparam logic [15:0] ID_LAST  = 16'hFFFF;

	typedef struct packed {
		logic [15:0] id;
		logic [3:0]  prio;
	} slot_t;

endpackage

[hdl/spq_ram.sv]
`timescale 1ns / 1ps
module spq_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/sorted_priority_queue.sv]
`timescale 1ns / 1ps
// Sorted priority queue of up to CAPACITY entries held in one RAM as a ring that starts at a
// head pointer, highest priority first. Refused adds, full, empty, clear and an add into an
// empty queue are answered straight from idle. Remove steps through the accept, the RAM read
// and the result. An add walks from the tail toward the front, moving each lower-or-equal
// entry up one slot: a read and a compare-and-move per entry, then the write of the new entry.
// List reads and emits each stored entry in turn. The RAM has a single read port with a
// registered read; a stalled result register holds the add, remove and list in place.
`include "sorted_priority_queue_macros.svh"
module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [3:0]  prio_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] entry_id,
	output logic [3:0]  entry_prio,
	output logic        last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);
	localparam logic [AW:0] CAP_W = (AW + 1)'(CAPACITY);
	localparam logic [OW-1:0] CAP_O = OW'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_A_RD  = 3'd1;
	localparam logic [2:0] S_A_CMP = 3'd2;
	localparam logic [2:0] S_A_FIN = 3'd3;
	localparam logic [2:0] S_R_RD  = 3'd4;
	localparam logic [2:0] S_R_OUT = 3'd5;
	localparam logic [2:0] S_L_RD  = 3'd6;
	localparam logic [2:0] S_L_OUT = 3'd7;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [OW-1:0] occ_q, occ_d;
	logic [15:0]   next_id_q, next_id_d;
	logic [AW-1:0] k_q, k_d;
	logic [3:0]    cmd_prio_q, cmd_prio_d;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] id_q;
	logic [3:0]  prio_q;
	logic        last_q;

	logic        emit;
	logic [2:0]  emit_status;
	logic [15:0] emit_id;
	logic [3:0]  emit_prio;
	logic        emit_last;

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	slot_t         wr_data, rd_slot;
	logic [$bits(slot_t)-1:0] rd_raw;

	logic out_free, in_acc, prio_ok;
	logic [15:0] id_bump;

	// Logical position in the ring to physical RAM address.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] k);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, k};
		if (sum >= CAP_W) begin
			sum = sum - CAP_W;
		end
		return sum[AW-1:0];
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign prio_ok  = (prio_in >= PRIO_MIN) && (prio_in <= PRIO_MAX);
	assign id_bump  = (next_id_q == ID_LAST) ? ID_FIRST : next_id_q + 16'd1;
	assign rd_slot  = slot_t'(rd_raw);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		occ_d      = occ_q;
		next_id_d  = next_id_q;
		k_d        = k_q;
		cmd_prio_d = cmd_prio_q;
		emit        = 1'b0;
		emit_status = ST_ADDED;
		emit_id     = '0;
		emit_prio   = '0;
		emit_last   = 1'b1;
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = '{id: next_id_q, prio: cmd_prio_q};
		rd_en   = 1'b0;
		rd_addr = phys(head_q, k_q);

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (mode)
						MODE_ADD: begin
							if (!prio_ok) begin
								emit        = 1'b1;
								emit_status = ST_BAD_PRIO;
							end else if (occ_q == CAP_O) begin
								emit        = 1'b1;
								emit_status = ST_FULL;
							end else if (occ_q == '0) begin
								wr_en       = 1'b1;
								wr_addr     = head_q;
								wr_data     = '{id: next_id_q, prio: prio_in};
								emit        = 1'b1;
								emit_status = ST_ADDED;
								emit_id     = next_id_q;
								emit_prio   = prio_in;
								next_id_d   = id_bump;
								occ_d       = occ_q + OW'(1);
							end else begin
								k_d        = AW'(occ_q - OW'(1));
								cmd_prio_d = prio_in;
								state_d    = S_A_RD;
							end
						end
						MODE_REMOVE: begin
							if (occ_q == '0) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								state_d = S_R_RD;
							end
						end
						MODE_LIST: begin
							if (occ_q == '0) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								k_d     = '0;
								state_d = S_L_RD;
							end
						end
						MODE_CLEAR: begin
							occ_d       = '0;
							emit        = 1'b1;
							emit_status = ST_CLEARED;
						end
						default: begin
						end
					endcase
				end
			end
			S_A_RD: begin
				rd_en   = 1'b1;
				state_d = S_A_CMP;
			end
			S_A_CMP: begin
				if (rd_slot.prio > cmd_prio_q) begin
					// The new entry lands right behind the entry just read.
					if (out_free) begin
						wr_en       = 1'b1;
						wr_addr     = phys(head_q, k_q + AW'(1));
						emit        = 1'b1;
						emit_status = ST_ADDED;
						emit_id     = next_id_q;
						emit_prio   = cmd_prio_q;
						next_id_d   = id_bump;
						occ_d       = occ_q + OW'(1);
						state_d     = S_IDLE;
					end
				end else begin
					wr_en   = 1'b1;
					wr_addr = phys(head_q, k_q + AW'(1));
					wr_data = rd_slot;
					if (k_q == '0) begin
						state_d = S_A_FIN;
					end else begin
						k_d     = k_q - AW'(1);
						state_d = S_A_RD;
					end
				end
			end
			S_A_FIN: begin
				if (out_free) begin
					wr_en       = 1'b1;
					wr_addr     = head_q;
					emit        = 1'b1;
					emit_status = ST_ADDED;
					emit_id     = next_id_q;
					emit_prio   = cmd_prio_q;
					next_id_d   = id_bump;
					occ_d       = occ_q + OW'(1);
					state_d     = S_IDLE;
				end
			end
			S_R_RD: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
				state_d = S_R_OUT;
			end
			S_R_OUT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = ST_REMOVED;
					emit_id     = rd_slot.id;
					emit_prio   = rd_slot.prio;
					head_d      = phys(head_q, AW'(1));
					occ_d       = occ_q - OW'(1);
					state_d     = S_IDLE;
				end
			end
			S_L_RD: begin
				rd_en   = 1'b1;
				state_d = S_L_OUT;
			end
			S_L_OUT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = ST_LISTED;
					emit_id     = rd_slot.id;
					emit_prio   = rd_slot.prio;
					emit_last   = ({1'b0, k_q} == (AW + 1)'(occ_q - OW'(1)));
					k_d         = k_q + AW'(1);
					state_d     = emit_last ? S_IDLE : S_L_RD;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			next_id_q   <= ID_FIRST;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			occ_q     <= occ_d;
			next_id_q <= next_id_d;
			k_q       <= k_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_prio_q <= cmd_prio_d;
		if (emit) begin
			status_q <= emit_status;
			id_q     <= emit_id;
			prio_q   <= emit_prio;
			last_q   <= emit_last;
		end
	end

	spq_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign entry_id   = id_q;
	assign entry_prio = prio_q;
	assign last       = last_q;

	`SPQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= CAP_O)
	`SPQ_ASSERT_NEXT(a_clear_empties, in_acc && (mode == MODE_CLEAR), occ_q == '0)
	`SPQ_ASSERT_NOW(a_partial_list, out_valid_q && !last_q, (state_q == S_L_RD) || (state_q == S_L_OUT))

endmodule
